// File: sv/tnes_pkg.sv
package tnes_pkg;

  localparam int unsigned NoteMax = 127;
  localparam int unsigned SwingNone = 50;

  typedef enum logic [1:0] {
    MODE_SCHED = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_CUT   = 2'd3
  } mode_e;

  typedef enum logic {
    KIND_ON  = 1'b0,
    KIND_OFF = 1'b1
  } kind_e;

  localparam logic CfgMask  = 1'b0;
  localparam logic CfgSwing = 1'b1;

  typedef struct packed {
    logic        active;
    logic        on_sent;
    logic        off_done;
    logic [6:0]  note;
    logic [3:0]  channel;
    logic [6:0]  velocity;
    logic [3:0]  track;
    logic [31:0] on_time;
    logic [31:0] off_time;
    logic [6:0]  played_note;
  } slot_t;

endpackage

// File: sv/tnes_arith.sv
module tnes_arith import tnes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [6:0]  swing_i,
  input  logic [31:0] start_phase_i,
  input  logic [23:0] length_i,
  input  logic [6:0]  gate_i,
  input  logic [11:0] swing_max_i,
  input  logic        beat_odd_i,
  output logic        done_o,
  output logic [31:0] on_o,
  output logic [31:0] off_o
);

  logic [2:0]  step_q, step_d;
  logic [30:0] prod_q, prod_d;
  logic [24:0] quot_q, quot_d;
  logic [31:0] on_q, on_d;
  logic [31:0] off_q, off_d;
  logic [32:0] sum;
  logic [18:0] swd;
  logic [6:0]  sw_ex;

  assign sw_ex = swing_i - 7'(SwingNone);
  assign swd   = 19'(sw_ex) * 19'(swing_max_i);
  assign sum   = 33'(on_q) + 33'(quot_q);

  // truncating /100 by reciprocal and correction
  function automatic logic [24:0] div100_31(input logic [30:0] x);
    logic [63:0] m;
    logic [24:0] q;
    logic [31:0] r;
    m = 64'(x) * 64'd2748779070;
    q = 25'(m >> 38);
    r = 32'(x) - 32'(q) * 32'd100;
    if (r >= 32'd100) q = q + 25'd1;
    return q;
  endfunction

  always_comb begin
    step_d = step_q;
    prod_d = prod_q;
    quot_d = quot_q;
    on_d   = on_q;
    off_d  = off_q;
    case (step_q)
      3'd0: if (start_i) begin
        prod_d = 31'(swd);
        step_d = 3'd1;
      end
      3'd1: begin
        quot_d = div100_31(prod_q);
        prod_d = 31'(length_i) * 31'(gate_i);
        step_d = 3'd2;
      end
      3'd2: begin
        on_d = start_phase_i;
        if (swing_i > 7'(SwingNone) && beat_odd_i) begin
          if (33'(start_phase_i) + 33'(quot_q) > 33'hFFFFFFFF) on_d = '1;
          else on_d = start_phase_i + 32'(quot_q);
        end
        quot_d = div100_31(prod_q);
        step_d = 3'd3;
      end
      3'd3: begin
        off_d  = sum[32] ? '1 : sum[31:0];
        step_d = 3'd4;
      end
      default: step_d = 3'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quot_q <= quot_d;
    on_q   <= on_d;
    off_q  <= off_d;
  end

  assign done_o = (step_q == 3'd4);
  assign on_o   = on_q;
  assign off_o  = off_q;

endmodule

// File: sv/tnes_cell.sv
module tnes_cell import tnes_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  load_i,
  input  slot_t load_slot_i,
  input  slot_t prev_i,
  output slot_t slot_o
);

  slot_t slot_q;
  logic  act_q, ons_q, offs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      ons_q  <= 1'b0;
      offs_q <= 1'b0;
    end else if (load_i) begin
      act_q  <= load_slot_i.active;
      ons_q  <= load_slot_i.on_sent;
      offs_q <= load_slot_i.off_done;
    end else if (shift_i) begin
      act_q  <= prev_i.active;
      ons_q  <= prev_i.on_sent;
      offs_q <= prev_i.off_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) slot_q <= load_slot_i;
    else if (shift_i) slot_q <= prev_i;
  end

  always_comb begin
    slot_o          = slot_q;
    slot_o.active   = act_q;
    slot_o.on_sent  = ons_q;
    slot_o.off_done = offs_q;
  end

endmodule

// File: sv/timed_note_event_scheduler.sv
// Timed note event scheduler: a ring of SLOTS note slots.
// Input channel (in_valid_i / in_stall_o) takes one request: schedule, tick,
// clear all or cut channel. Results leave on out_valid_o / out_stall_i, one
// event per handshake; last_o marks the final event of a request.
// The slots circulate through a chain of cells; the head cell is inspected
// and updated once per cycle while the rotation is not paused, slots visited
// in ascending order. A schedule runs the on/off arithmetic, then one
// rotation to find the conflicting and the free slot and one to apply them.
// A tick, clear or cut takes one rotation, in which a slot whose note starts
// and ends in the same tick is visited twice. One request at a time;
// in_stall_o is high while busy. Each event waits in a hold register until
// the next one appears or the rotation ends, then moves to the output
// register. When both are full the rotation pauses until the receiver takes
// the output; nothing is lost. A request with no events gives no output.
// The user must make configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i)
// while idle; the block does not enforce it. Reset empties the table, clears
// chord follow and sets swing delay to 1024. No clearing pass is needed:
// reset clears the slot flags at once.
module timed_note_event_scheduler import tnes_pkg::*; #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TRACKS    = 16,
  parameter int unsigned FRAC_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] now_phase_i,
  input  logic [6:0]  note_i,
  input  logic [6:0]  velocity_i,
  input  logic [3:0]  channel_i,
  input  logic [6:0]  swing_i,
  input  logic [31:0] start_phase_i,
  input  logic [23:0] length_i,
  input  logic [6:0]  gate_i,
  input  logic [3:0]  track_i,
  input  logic [7:0]  live_transpose_i,
  input  logic [7:0]  step_transpose_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [6:0]  out_note_o,
  output logic [6:0]  out_velocity_o,
  output logic [3:0]  out_channel_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ARITH, ST_FIND, ST_APPLY, ST_SCAN, ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic [15:0] mask_q;
  logic [11:0] swmax_q;
  mode_e       mode_q;
  logic [31:0] now_q;
  logic [6:0]  note_q, vel_q, swing_q, gate_q;
  logic [3:0]  ch_q, track_q;
  logic [31:0] start_q;
  logic [23:0] len_q;
  logic signed [7:0] tr_q;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic        hasc_q, hasc_d, hasf_q, hasf_d;
  logic [IdxW-1:0] cidx_q, cidx_d, fidx_q, fidx_d;
  logic [31:0] on_q, off_q;
  logic        sec_q, sec_d;

  // held event: last flag known once the next one shows up
  logic        hv_q, hv_d, hkind_q;
  logic [6:0]  hnote_q, hvel_q;
  logic [3:0]  hch_q;
  logic        ov_q, ov_d, okind_q, olast_q;
  logic [6:0]  onote_q, ovel_q;
  logic [3:0]  och_q;

  slot_t chain [SLOTS];
  slot_t head, head_new;

  logic        ar_done;
  logic [31:0] ar_on, ar_off;

  logic        in_acc, busy_rot, o_free, room, step, shift, push, flush, is_last;
  logic        match, trunc, kill, fol, on_due, off_due, split;
  logic signed [8:0] fin;
  logic [6:0]  fin7;
  logic        ev_v, ev_kind;
  logic [6:0]  ev_note, ev_vel;
  logic [3:0]  ev_ch;

  tnes_arith u_arith (
    .clk_i, .rst_ni,
    .start_i      (state_q == ST_ARITH),
    .swing_i      (swing_q),
    .start_phase_i(start_q),
    .length_i     (len_q),
    .gate_i       (gate_q),
    .swing_max_i  (swmax_q),
    .beat_odd_i   (start_q[FRAC_BITS]),
    .done_o       (ar_done),
    .on_o         (ar_on),
    .off_o        (ar_off)
  );

  assign head = chain[SLOTS-1];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_first
      tnes_cell u_cell (
        .clk_i, .rst_ni,
        .shift_i    (shift),
        .load_i     (shift),
        .load_slot_i(head_new),
        .prev_i     (head),
        .slot_o     (chain[g])
      );
    end else begin : g_rest
      tnes_cell u_cell (
        .clk_i, .rst_ni,
        .shift_i    (shift),
        .load_i     (1'b0),
        .load_slot_i(head_new),
        .prev_i     (chain[g-1]),
        .slot_o     (chain[g])
      );
    end
  end

  assign in_acc   = (state_q == ST_IDLE) && in_valid_i;
  assign busy_rot = (state_q == ST_FIND) || (state_q == ST_APPLY) || (state_q == ST_SCAN);
  assign o_free   = !ov_q || !out_stall_i;
  assign room     = !hv_q || o_free;
  assign step     = busy_rot && (!ev_v || room);
  assign shift    = step && !split;
  assign push     = step && ev_v;
  assign flush    = (state_q == ST_FLUSH) && hv_q && o_free;
  assign is_last  = (cnt_q == IdxW'(SLOTS - 1));

  assign match = head.active && head.note == note_q && head.channel == ch_q &&
                 !head.off_done;
  assign trunc = (on_q >= 32'd1) && (on_q - 32'd1 > now_q);
  // conflicting slot that this request frees is also a free slot candidate
  assign kill  = match && !hasc_q && (on_q < head.off_time) && !trunc && head.on_sent;
  assign fol   = (32'(head.track) < TRACKS) && mask_q[head.track];
  assign fin   = signed'({2'b00, head.note}) + 9'(tr_q);
  assign fin7  = (fin < 9'sd0) ? 7'd0 :
                 ((fin > signed'(9'(NoteMax))) ? 7'(NoteMax) : fin[6:0]);

  assign on_due  = head.active && !head.on_sent && (now_q >= head.on_time);
  assign off_due = head.active && (head.on_sent || on_due) && !head.off_done &&
                   (now_q >= head.off_time);
  // a slot that starts and ends in one tick: note-on first, off on the second visit
  assign split   = (state_q == ST_SCAN) && (mode_q == MODE_TICK) && on_due && off_due &&
                   !sec_q;

  always_comb begin
    head_new = head;
    ev_v     = 1'b0;
    ev_kind  = KIND_OFF;
    ev_note  = head.played_note;
    ev_vel   = '0;
    ev_ch    = head.channel;
    case (state_q)
      ST_APPLY: begin
        if (hasc_q && cnt_q == cidx_q && on_q < head.off_time) begin
          if (trunc) begin
            head_new.off_time = on_q - 32'd1;
          end else if (head.on_sent) begin
            ev_v              = 1'b1;
            head_new.active   = 1'b0;
            head_new.off_done = 1'b1;
          end
        end
        if (hasf_q && cnt_q == fidx_q) begin
          head_new.active      = 1'b1;
          head_new.on_sent     = 1'b0;
          head_new.off_done    = 1'b0;
          head_new.note        = note_q;
          head_new.channel     = ch_q;
          head_new.velocity    = vel_q;
          head_new.track       = track_q;
          head_new.on_time     = on_q;
          head_new.off_time    = off_q;
          head_new.played_note = '0;
        end
      end
      ST_SCAN: begin
        if (mode_q == MODE_TICK) begin
          if (on_due) begin
            head_new.on_sent     = 1'b1;
            head_new.played_note = fol ? fin7 : head.note;
            if (!sec_q) begin
              ev_v    = 1'b1;
              ev_kind = KIND_ON;
              ev_note = head_new.played_note;
              ev_vel  = head.velocity;
            end
          end
          if (off_due) begin
            head_new.off_done = 1'b1;
            head_new.active   = 1'b0;
            if (!on_due || sec_q) begin
              ev_v    = 1'b1;
              ev_note = head_new.played_note;
            end
          end
        end else if (mode_q == MODE_CLEAR || (head.active && head.channel == ch_q)) begin
          ev_v              = head.active && head.on_sent && !head.off_done;
          head_new.active   = 1'b0;
          head_new.on_sent  = 1'b0;
          head_new.off_done = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hasc_d  = hasc_q;
    hasf_d  = hasf_q;
    cidx_d  = cidx_q;
    fidx_d  = fidx_q;
    sec_d   = sec_q;
    hv_d    = hv_q;
    ov_d    = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if ((push && hv_q) || flush) ov_d = 1'b1;
    if (push) hv_d = 1'b1;
    if (flush) hv_d = 1'b0;
    if (step) sec_d = split;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = '0;
          hasc_d  = 1'b0;
          hasf_d  = 1'b0;
          sec_d   = 1'b0;
          state_d = (mode_i == MODE_SCHED) ? ST_ARITH : ST_SCAN;
        end
      end
      ST_ARITH: begin
        if (ar_done) state_d = ST_FIND;
      end
      ST_FLUSH: begin
        if (!hv_q || o_free) state_d = ST_IDLE;
      end
      default: begin
        if (shift) begin
          cnt_d = is_last ? '0 : cnt_q + IdxW'(1);
          if (state_q == ST_FIND) begin
            if (match && !hasc_q) begin
              hasc_d = 1'b1;
              cidx_d = cnt_q;
            end
            if ((!head.active || kill) && !hasf_q) begin
              hasf_d = 1'b1;
              fidx_d = cnt_q;
            end
            if (is_last) state_d = ST_APPLY;
          end else if (is_last) begin
            state_d = ST_FLUSH;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mask_q  <= '0;
      swmax_q <= 12'd1024;
      mode_q  <= MODE_SCHED;
      now_q   <= '0;
      note_q  <= '0;
      vel_q   <= '0;
      swing_q <= '0;
      gate_q  <= '0;
      ch_q    <= '0;
      track_q <= '0;
      start_q <= '0;
      len_q   <= '0;
      tr_q    <= '0;
      cnt_q   <= '0;
      hasc_q  <= 1'b0;
      hasf_q  <= 1'b0;
      cidx_q  <= '0;
      fidx_q  <= '0;
      on_q    <= '0;
      off_q   <= '0;
      sec_q   <= 1'b0;
      hv_q    <= 1'b0;
      hkind_q <= 1'b0;
      hnote_q <= '0;
      hvel_q  <= '0;
      hch_q   <= '0;
      ov_q    <= 1'b0;
      okind_q <= 1'b0;
      olast_q <= 1'b0;
      onote_q <= '0;
      ovel_q  <= '0;
      och_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hasc_q  <= hasc_d;
      hasf_q  <= hasf_d;
      cidx_q  <= cidx_d;
      fidx_q  <= fidx_d;
      sec_q   <= sec_d;
      hv_q    <= hv_d;
      ov_q    <= ov_d;
      if (cfg_we_i && cfg_idx_i == CfgMask) mask_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CfgSwing) swmax_q <= cfg_data_i[11:0];
      if (in_acc) begin
        mode_q  <= mode_e'(mode_i);
        now_q   <= now_phase_i;
        note_q  <= note_i;
        vel_q   <= velocity_i;
        ch_q    <= channel_i;
        swing_q <= swing_i;
        start_q <= start_phase_i;
        len_q   <= length_i;
        gate_q  <= gate_i;
        track_q <= track_i;
        tr_q    <= (live_transpose_i != 8'd0) ? live_transpose_i : step_transpose_i;
      end
      if (state_q == ST_ARITH && ar_done) begin
        on_q  <= ar_on;
        off_q <= ar_off;
      end
      if (push) begin
        hkind_q <= ev_kind;
        hnote_q <= ev_note;
        hvel_q  <= ev_vel;
        hch_q   <= ev_ch;
      end
      if ((push && hv_q) || flush) begin
        okind_q <= hkind_q;
        onote_q <= hnote_q;
        ovel_q  <= hvel_q;
        och_q   <= hch_q;
        olast_q <= flush;
      end
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = ov_q;
  assign kind_o         = okind_q;
  assign out_note_o     = onote_q;
  assign out_velocity_o = ovel_q;
  assign out_channel_o  = och_q;
  assign last_o         = olast_q;

endmodule

// File: tb/testbench.sv
module testbench;
  import tnes_pkg::*;

  localparam int unsigned NSLOT = 16;
  localparam int unsigned FRACB = 10;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic       kind;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [3:0] channel;
    logic       last;
  } note_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [31:0] now_phase_i = '0;
  logic [6:0]  note_i = '0;
  logic [6:0]  velocity_i = '0;
  logic [3:0]  channel_i = '0;
  logic [6:0]  swing_i = '0;
  logic [31:0] start_phase_i = '0;
  logic [23:0] length_i = '0;
  logic [6:0]  gate_i = '0;
  logic [3:0]  track_i = '0;
  logic [7:0]  live_transpose_i = '0;
  logic [7:0]  step_transpose_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [6:0]  out_note_o;
  logic [6:0]  out_velocity_o;
  logic [3:0]  out_channel_o;
  logic        last_o;

  timed_note_event_scheduler DUT (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [15:0] follow_mask;
  logic [11:0] swing_span;
  slot_t       slot_q [NSLOT];
  note_event_t pending_events [$];

  int  mismatches = 0;
  int  events_seen = 0;
  int  requests_sent = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  longint unsigned cycle_count = 0;
  logic [31:0] now_q = 0;

  function automatic note_event_t mk_event(logic kind, logic [6:0] nt, logic [6:0] vel,
                                           logic [3:0] ch);
    note_event_t e;
    e.kind = kind;
    e.note = nt;
    e.velocity = vel;
    e.channel = ch;
    e.last = 1'b0;
    return e;
  endfunction

  task automatic predict_request(mode_e md, logic [31:0] now, logic [6:0] nt,
                                 logic [6:0] vel, logic [3:0] ch, logic [6:0] sw,
                                 logic [31:0] start, logic [23:0] len, logic [6:0] gt,
                                 logic [3:0] trk, logic [7:0] live, logic [7:0] stp);
    note_event_t evs [$];
    logic [63:0] on_t, off_t;
    int conflict, free_idx, fin, tr;
    conflict = -1;
    free_idx = -1;
    case (md)
      MODE_SCHED: begin
        on_t = start;
        if (sw > SwingNone && start[FRACB])
          on_t += (64'(sw) - 50) * 64'(swing_span) / 100;
        if (on_t > 64'hFFFF_FFFF) on_t = 64'hFFFF_FFFF;
        off_t = on_t + 64'(len) * 64'(gt) / 100;
        if (off_t > 64'hFFFF_FFFF) off_t = 64'hFFFF_FFFF;
        for (int i = 0; i < NSLOT; i++)
          if (conflict < 0 && slot_q[i].active && slot_q[i].note == nt &&
              slot_q[i].channel == ch && !slot_q[i].off_done) conflict = i;
        if (conflict >= 0 && on_t < 64'(slot_q[conflict].off_time)) begin
          if (on_t >= 1 && on_t - 1 > 64'(now)) begin
            slot_q[conflict].off_time = 32'(on_t - 1);
          end else if (slot_q[conflict].on_sent) begin
            evs.push_back(mk_event(KIND_OFF, slot_q[conflict].played_note, 7'd0, ch));
            slot_q[conflict].off_done = 1'b1;
            slot_q[conflict].active = 1'b0;
          end
        end
        for (int i = 0; i < NSLOT; i++)
          if (free_idx < 0 && !slot_q[i].active) free_idx = i;
        if (free_idx >= 0) begin
          slot_q[free_idx] = '{active: 1'b1, on_sent: 1'b0, off_done: 1'b0, note: nt,
                               channel: ch, velocity: vel, track: trk,
                               on_time: 32'(on_t), off_time: 32'(off_t),
                               played_note: 7'd0};
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!slot_q[i].active) continue;
          if (!slot_q[i].on_sent && now >= slot_q[i].on_time) begin
            fin = slot_q[i].note;
            if (follow_mask[slot_q[i].track]) begin
              tr = (live != 0) ? $signed(live) : $signed(stp);
              fin += tr;
              if (fin < 0) fin = 0;
              if (fin > NoteMax) fin = NoteMax;
            end
            evs.push_back(mk_event(KIND_ON, 7'(fin), slot_q[i].velocity,
                                   slot_q[i].channel));
            slot_q[i].played_note = 7'(fin);
            slot_q[i].on_sent = 1'b1;
          end
          if (slot_q[i].on_sent && !slot_q[i].off_done && now >= slot_q[i].off_time) begin
            evs.push_back(mk_event(KIND_OFF, slot_q[i].played_note, 7'd0,
                                   slot_q[i].channel));
            slot_q[i].off_done = 1'b1;
            slot_q[i].active = 1'b0;
          end
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (md == MODE_CUT && !(slot_q[i].active && slot_q[i].channel == ch)) continue;
          if (slot_q[i].active && slot_q[i].on_sent && !slot_q[i].off_done)
            evs.push_back(mk_event(KIND_OFF, slot_q[i].played_note, 7'd0,
                                   slot_q[i].channel));
          slot_q[i].active = 1'b0;
          slot_q[i].on_sent = 1'b0;
          slot_q[i].off_done = 1'b0;
        end
      end
    endcase
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endtask

  task automatic send_request(mode_e md, logic [31:0] now, logic [6:0] nt,
                              logic [6:0] vel, logic [3:0] ch, logic [6:0] sw,
                              logic [31:0] start, logic [23:0] len, logic [6:0] gt,
                              logic [3:0] trk, logic [7:0] live, logic [7:0] stp);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= md;
    now_phase_i <= now;
    note_i <= nt;
    velocity_i <= vel;
    channel_i <= ch;
    swing_i <= sw;
    start_phase_i <= start;
    length_i <= len;
    gate_i <= gt;
    track_i <= trk;
    live_transpose_i <= live;
    step_transpose_i <= stp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(md, now, nt, vel, ch, sw, start, len, gt, trk, live, stp);
    requests_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic sched_note(logic [31:0] start, logic [23:0] len, logic [6:0] nt,
                            logic [3:0] ch, logic [6:0] sw = 0, logic [6:0] gt = 100,
                            logic [3:0] trk = 0, logic [6:0] vel = 100);
    send_request(MODE_SCHED, now_q, nt, vel, ch, sw, start, len, gt, trk, 8'($urandom),
                 8'($urandom));
  endtask

  task automatic tick_at(logic [31:0] now, logic [7:0] live = 0, logic [7:0] stp = 0);
    now_q = now;
    send_request(MODE_TICK, now, 7'($urandom), 7'($urandom), 4'($urandom),
                 7'($urandom), $urandom, 24'($urandom), 7'($urandom), 4'($urandom),
                 live, stp);
  endtask

  task automatic wait_drained();
    while (pending_events.size() > 0) @(negedge clk_i);
    repeat (3 * NSLOT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMask) follow_mask = val;
    else swing_span = val[11:0];
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    note_event_t exp_ev;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected event kind=%0d note=%0d ch=%0d", kind_o, out_note_o,
                   out_channel_o);
      end else begin
        exp_ev = pending_events.pop_front();
        if (kind_o !== exp_ev.kind || out_note_o !== exp_ev.note ||
            out_velocity_o !== exp_ev.velocity || out_channel_o !== exp_ev.channel ||
            last_o !== exp_ev.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Event mismatch: exp k%0d n%0d v%0d c%0d l%0d, got k%0d n%0d v%0d c%0d l%0d",
                     exp_ev.kind, exp_ev.note, exp_ev.velocity, exp_ev.channel,
                     exp_ev.last, kind_o, out_note_o, out_velocity_o, out_channel_o,
                     last_o);
        end
      end
    end
  end

  task automatic test_directed();
    write_reg(CfgMask, 16'hFFFF);
    write_reg(CfgSwing, 12'd2048);
    sched_note(32'd0, 24'd0, 7'd0, 4'd0, 7'd0, 7'd0, 4'd0, 7'd0);
    sched_note(32'h0000_0400, 24'hFF_FFFF, 7'd127, 4'd15, 7'd100, 7'd100, 4'd15, 7'd127);
    sched_note(32'hFFFF_FC00, 24'hFF_FFFF, 7'd60, 4'd3, 7'd127, 7'd127, 4'd1, 7'd64);
    sched_note(32'h0000_0C00, 24'd2048, 7'd10, 4'd2, 7'd75, 7'd50, 4'd2, 7'd1);
    tick_at(32'h0000_0000, 8'h7F, 8'h00);
    tick_at(32'h0000_0800, 8'h00, 8'h80);
    tick_at(32'h0000_1000, 8'h80, 8'h05);
    // conflict: truncate pending, then end sounding
    sched_note(32'h0000_1000, 24'h1000, 7'd20, 4'd4);
    tick_at(32'h0000_1000);
    sched_note(32'h0000_1800, 24'h1000, 7'd20, 4'd4);
    sched_note(32'h0000_1001, 24'h100, 7'd20, 4'd4);
    tick_at(32'h0000_3000);
    for (int i = 0; i < 17; i++)
      sched_note(32'h0000_4000, 24'h400, 7'(i), 4'(i), 7'd0, 7'd100, 4'(i));
    tick_at(32'h0000_4000, 8'h03, 8'h00);
    send_request(MODE_CUT, now_q, 0, 0, 4'd5, 0, 0, 0, 0, 0, 0, 0);
    send_request(MODE_CLEAR, now_q, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    write_reg(CfgMask, 16'h0000);
    write_reg(CfgSwing, 12'd0);
  endtask

  task automatic test_random(int n_items);
    logic [31:0] base;
    int r;
    for (int k = 0; k < n_items; k++) begin
      base = now_q;
      r = $urandom_range(99);
      if (r < 50)
        sched_note(base + $urandom_range(8192), 24'($urandom_range(6000)),
                   7'($urandom_range(3) * 40 + $urandom_range(7)), 4'($urandom_range(3)),
                   7'($urandom_range(127)), 7'($urandom_range(127)), 4'($urandom),
                   7'($urandom));
      else if (r < 55)
        sched_note($urandom, 24'($urandom), 7'($urandom), 4'($urandom),
                   7'($urandom), 7'($urandom), 4'($urandom), 7'($urandom));
      else if (r < 92)
        tick_at(base + $urandom_range(3000), 8'($urandom_range(3) == 0 ? $urandom : 0),
                8'($urandom));
      else if (r < 96)
        send_request(MODE_CUT, now_q, 7'($urandom), 7'($urandom), 4'($urandom_range(3)),
                     7'($urandom), $urandom, 24'($urandom), 7'($urandom), 4'($urandom),
                     8'($urandom), 8'($urandom));
      else
        send_request(MODE_CLEAR, now_q, 7'($urandom), 7'($urandom), 4'($urandom),
                     7'($urandom), $urandom, 24'($urandom), 7'($urandom), 4'($urandom),
                     8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_phase(int idle, int stall, logic [15:0] mask, logic [11:0] swd);
    send_idle_pct = idle;
    stall_pct = stall;
    write_reg(CfgMask, mask);
    write_reg(CfgSwing, swd);
    test_random(110);
  endtask

  initial begin
    follow_mask = '0;
    swing_span = 12'd1024;
    foreach (slot_q[i]) slot_q[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_phase(0, 0, 16'hA5A5, 12'd1024);
    test_phase(78, 0, 16'hFFFF, 12'd2048);
    test_phase(0, 78, 16'h0F0F, 12'd0);
    test_phase(25, 25, 16'($urandom), 12'($urandom_range(2048)));
    wait_drained();
    $display("Sent %0d requests (schedule, tick, cut, clear) and checked %0d events",
             requests_sent, events_seen);
    $display("over four idle/stall phases and several register settings.");
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d events missing", mismatches, pending_events.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tnes_pkg.sv
sv/tnes_arith.sv
sv/tnes_cell.sv
sv/timed_note_event_scheduler.sv
tb/testbench.sv
